FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the root solver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising edge and ignored while reset is active.
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define QRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int ROOT_W    = 32;
  localparam int LIMIT_W   = 16;
  localparam int STATUS_W  = 2;
  // Fraction bits of the Q8.8 coefficients.
  localparam int COEF_FRAC = 8;
  // Pipeline depth of the residual unit.
  localparam int RES_LAT   = 6;

  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [ROOT_W-1:0] root_t;
  typedef logic [LIMIT_W-1:0]       limit_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_AZERO  = 2'd1;
  localparam status_t ST_NOREAL = 2'd2;
  localparam status_t ST_RESID  = 2'd3;

  localparam limit_t LIMIT_RST = 16'd7;

  // Special-case flags that travel down the pipeline with each word.
  typedef struct packed {
    logic azero;
    logic noreal;
  } qrs_flags_t;

endpackage

FILE: rtl/qrs_if.sv
// Handshake channel interfaces for coefficient words and root words.
`timescale 1ns / 1ps
interface qrs_coef_if #(parameter int COEF_BITS = 16) ();
  logic                        valid;
  logic                        ready;
  logic signed [COEF_BITS-1:0] coef_quad;
  logic signed [COEF_BITS-1:0] coef_lin;
  logic signed [COEF_BITS-1:0] coef_const;

  modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
  modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface qrs_root_if ();
  import qrs_pkg::*;
  logic    valid;
  logic    ready;
  root_t   root_plus;
  root_t   root_minus;
  status_t status;

  modport source (output valid, root_plus, root_minus, status, input ready);
  modport sink (input valid, root_plus, root_minus, status, output ready);
endinterface

FILE: rtl/qrs_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per word.
`timescale 1ns / 1ps
module qrs_sqrt_cell #(
  parameter int S_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [2*S_W-1:0]  rad_i,
  input  logic [S_W+1:0]    rem_i,
  input  logic [S_W-1:0]    root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [2*S_W-1:0]  rad_o,
  output logic [S_W+1:0]    rem_o,
  output logic [S_W-1:0]    root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [S_W+1:0]    rem_sh;
  logic [S_W+1:0]    trial;
  logic [S_W+2:0]    diff;
  logic              ge;
  logic [S_W+1:0]    rem_nxt;
  logic [S_W-1:0]    root_nxt;
  logic [2*S_W-1:0]  rad_nxt;
  logic              v_r;
  logic [2*S_W-1:0]  rad_r;
  logic [S_W+1:0]    rem_r;
  logic [S_W-1:0]    root_r;
  logic [SIDE_W-1:0] side_r;

  // Bring down the next radicand bit pair and try 4*root+1 against it.
  assign rem_sh   = {rem_i[S_W-1:0], rad_i[2*S_W-1 -: 2]};
  assign trial    = {root_i, 2'b01};
  assign diff     = {1'b0, rem_sh} - {1'b0, trial};
  assign ge       = ~diff[S_W+2];
  assign rem_nxt  = ge ? diff[S_W+1:0] : rem_sh;
  assign root_nxt = {root_i[S_W-2:0], ge};
  assign rad_nxt  = {rad_i[2*S_W-3:0], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

FILE: rtl/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the two roots.
`timescale 1ns / 1ps
module qrs_div_cell #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  logic [1:0][NUM_W-1:0] num_i,
  input  logic [1:0][DEN_W-1:0] rem_i,
  input  logic [1:0][NUM_W-1:0] quo_i,
  input  logic [DEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  v_o,
  output logic [1:0][NUM_W-1:0] num_o,
  output logic [1:0][DEN_W-1:0] rem_o,
  output logic [1:0][NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0]      den_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic [1:0][DEN_W:0]   rem_sh;
  logic [1:0][DEN_W+1:0] diff;
  logic [1:0]            ge;
  logic [1:0][NUM_W-1:0] num_nxt;
  logic [1:0][DEN_W-1:0] rem_nxt;
  logic [1:0][NUM_W-1:0] quo_nxt;
  logic                  v_r;
  logic [1:0][NUM_W-1:0] num_r;
  logic [1:0][DEN_W-1:0] rem_r;
  logic [1:0][NUM_W-1:0] quo_r;
  logic [DEN_W-1:0]      den_r;
  logic [SIDE_W-1:0]     side_r;

  // Restoring division step, the two lanes share the divisor.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i]  = {rem_i[i], num_i[i][NUM_W-1]};
      diff[i]    = {1'b0, rem_sh[i]} - {2'b00, den_i};
      ge[i]      = ~diff[i][DEN_W+1];
      rem_nxt[i] = ge[i] ? diff[i][DEN_W-1:0] : rem_sh[i][DEN_W-1:0];
      quo_nxt[i] = {quo_i[i][NUM_W-2:0], ge[i]};
      num_nxt[i] = {num_i[i][NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign num_o  = num_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

FILE: rtl/qrs_resid.sv
// Pipelined residual check of one root against the polynomial.
`timescale 1ns / 1ps
module qrs_resid #(
  parameter int COEF_BITS      = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COEF_BITS-1:0] a_i,
  input  logic signed [COEF_BITS-1:0] b_i,
  input  logic signed [COEF_BITS-1:0] c_i,
  input  qrs_pkg::root_t              x_i,
  input  qrs_pkg::limit_t             limit_i,
  output logic                        fail_o
);
  import qrs_pkg::*;

  localparam int N    = COEF_BITS;
  localparam int F    = ROOT_FRAC_BITS;
  localparam int AX_W = N + ROOT_W;
  localparam int U_W  = N + 25;
  localparam int HI_W = U_W - 32;
  localparam int P_W  = U_W + 32;
  localparam int R_W  = 65;
  localparam logic [P_W-1:0] CAP = P_W'(1) << 62;

  logic signed [AX_W-1:0] ax1_r;
  logic signed [N-1:0]    b1_r, c1_r, c2_r, c3_r, c4_r;
  root_t                  x1_r;
  logic signed [U_W-1:0]  u_nxt;
  logic [U_W-1:0]         mu_nxt;
  logic [ROOT_W-1:0]      mx_nxt;
  logic [U_W-1:0]         mu2_r;
  logic [ROOT_W-1:0]      mx2_r;
  logic                   neg2_r, neg3_r, neg4_r;
  logic [63:0]            plo3_r;
  logic [U_W-1:0]         phi3_r;
  logic [P_W-1:0]         p_sum;
  logic [62:0]            pm_nxt;
  logic [62:0]            pm4_r;
  logic signed [63:0]     q_val;
  logic signed [R_W-1:0]  r_nxt;
  logic signed [R_W-1:0]  r5_r;
  logic [R_W-1:0]         rmag;
  logic                   fail6_r;

  // u = floor(a*x / 2^8) + b * 2^(F-8); magnitudes feed the split multiply.
  assign u_nxt  = U_W'(ax1_r >>> COEF_FRAC) + (U_W'(b1_r) <<< (F - COEF_FRAC));
  assign mu_nxt = u_nxt[U_W-1] ? U_W'(-u_nxt) : U_W'(u_nxt);
  assign mx_nxt = x1_r[ROOT_W-1] ? ROOT_W'(-x1_r) : ROOT_W'(x1_r);

  // |u*x| clamped to 2^62.
  assign p_sum  = P_W'(plo3_r) + (P_W'(phi3_r) << 32);
  assign pm_nxt = (p_sum > CAP) ? CAP[62:0] : p_sum[62:0];

  assign q_val  = neg4_r ? -$signed({1'b0, pm4_r}) : $signed({1'b0, pm4_r});
  assign r_nxt  = R_W'(q_val >>> F) + (R_W'(c4_r) <<< (F - COEF_FRAC));
  assign rmag   = r5_r[R_W-1] ? R_W'(-r5_r) : R_W'(r5_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r   <= a_i * x_i;
      b1_r    <= b_i;
      c1_r    <= c_i;
      x1_r    <= x_i;
      mu2_r   <= mu_nxt;
      mx2_r   <= mx_nxt;
      neg2_r  <= u_nxt[U_W-1] ^ x1_r[ROOT_W-1];
      c2_r    <= c1_r;
      plo3_r  <= 64'(mu2_r[31:0]) * 64'(mx2_r);
      phi3_r  <= U_W'(mu2_r[U_W-1 -: HI_W]) * U_W'(mx2_r);
      neg3_r  <= neg2_r;
      c3_r    <= c2_r;
      pm4_r   <= pm_nxt;
      neg4_r  <= neg3_r;
      c4_r    <= c3_r;
      r5_r    <= r_nxt;
      fail6_r <= rmag > R_W'(limit_i);
    end
  end

  assign fail_o = fail6_r;

endmodule

FILE: rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, square root, divide, residual check.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  in_coef   sink       coef_quad, coef_lin, coef_const (signed Q8.8)
//  out_root  source     root_plus, root_minus (signed Q16.16), status
//  cfg_*     write      residual_limit (16 bit, no read-back)
//
//  One coefficient word is taken every clock cycle while the skid register is empty.
//  A word passes two input stages, COEF_BITS + ROOT_FRAC_BITS + 1 square root cells,
//  one numerator stage, COEF_BITS + ROOT_FRAC_BITS + 2 divider cells, one saturation
//  stage, six residual stages and the output register, from which its result is taken.
//  Reset is synchronous and active low; it clears every valid bit and sets the
//  residual limit to 7. A stalled output word sits in the output register while
//  a skid register takes one more; only then does the whole chain hold.
//
module quadratic_root_solver #(
  parameter int COEF_BITS      = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  qrs_coef_if.sink                in_coef,
  qrs_root_if.source              out_root,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data
);
  import qrs_pkg::*;

  localparam int N       = COEF_BITS;
  localparam int F       = ROOT_FRAC_BITS;
  // Root of the discriminant, scaled by 2^F.
  localparam int S_W     = N + 1 + F;
  localparam int RAD_W   = 2 * S_W;
  localparam int D_W     = 2 * N + 3;
  // Magnitude of -b*2^F +- sqrt, and of 2a.
  localparam int NUM_W   = N + F + 2;
  localparam int NUM_SW  = NUM_W + 1;
  localparam int DEN_W   = N + 1;
  localparam int CMP_W   = (NUM_W > 33) ? NUM_W : 33;
  localparam int ABC_W   = 3 * N;
  localparam int SQ_SIDE = ABC_W + 2;
  localparam int DV_SIDE = ABC_W + 4;
  localparam logic [CMP_W-1:0] POS_LIM = CMP_W'(33'h0_7FFF_FFFF);
  localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(33'h0_8000_0000);

  // The whole chain moves together; it halts only when the skid register is full.
  logic en;

  limit_t limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Stage 1: the two products of the discriminant.
  logic                  v1_r;
  logic signed [N-1:0]   a1_r, b1_r, c1_r;
  logic signed [2*N-1:0] bb1_r, ac1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_coef.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= in_coef.coef_quad;
      b1_r  <= in_coef.coef_lin;
      c1_r  <= in_coef.coef_const;
      bb1_r <= in_coef.coef_lin * in_coef.coef_lin;
      ac1_r <= in_coef.coef_quad * in_coef.coef_const;
    end
  end

  // Stage 2: exact discriminant b^2 - 4ac and the radicand D * 2^(2F).
  logic signed [D_W-1:0] bb_ext, ac4, disc;
  logic                  v2_r;
  logic [RAD_W-1:0]      rad2_r;
  logic [SQ_SIDE-1:0]    side2_r;
  qrs_flags_t            fl2;

  assign bb_ext     = D_W'(bb1_r);
  assign ac4        = D_W'(ac1_r) <<< 2;
  assign disc       = bb_ext - ac4;
  assign fl2.azero  = (a1_r == '0);
  assign fl2.noreal = disc[D_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad2_r  <= RAD_W'(disc[2*N:0]) << (2 * F);
      side2_r <= {a1_r, b1_r, c1_r, fl2};
    end
  end

  // Square root chain, one root bit per cell.
  logic                sq_v    [S_W+1];
  logic [RAD_W-1:0]    sq_rad  [S_W+1];
  logic [S_W+1:0]      sq_rem  [S_W+1];
  logic [S_W-1:0]      sq_root [S_W+1];
  logic [SQ_SIDE-1:0]  sq_side [S_W+1];

  assign sq_v[0]    = v2_r;
  assign sq_rad[0]  = rad2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side2_r;

  for (genvar gi = 0; gi < S_W; gi++) begin : g_sqrt
    qrs_sqrt_cell #(
      .S_W    (S_W),
      .SIDE_W (SQ_SIDE)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[gi]),
      .rad_i  (sq_rad[gi]),
      .rem_i  (sq_rem[gi]),
      .root_i (sq_root[gi]),
      .side_i (sq_side[gi]),
      .v_o    (sq_v[gi+1]),
      .rad_o  (sq_rad[gi+1]),
      .rem_o  (sq_rem[gi+1]),
      .root_o (sq_root[gi+1]),
      .side_o (sq_side[gi+1])
    );
  end

  // Stage 3: numerators -b*2^F +- sqrt and divisor 2a as sign and magnitude.
  logic signed [N-1:0]      a3, b3;
  logic [ABC_W-1:0]         abc3;
  qrs_flags_t               fl3;
  logic signed [NUM_SW-1:0] nb, s_ext, np, nm;
  logic [N-1:0]             a_mag;
  logic                     v3_r;
  logic [1:0][NUM_W-1:0]    num3_r;
  logic [DEN_W-1:0]         den3_r;
  logic [DV_SIDE-1:0]       side3_r;

  assign abc3  = sq_side[S_W][SQ_SIDE-1 -: ABC_W];
  assign fl3   = sq_side[S_W][1:0];
  assign a3    = abc3[ABC_W-1 -: N];
  assign b3    = abc3[ABC_W-N-1 -: N];
  assign nb    = -(NUM_SW'(b3)) <<< F;
  assign s_ext = $signed(NUM_SW'(sq_root[S_W]));
  assign np    = nb + s_ext;
  assign nm    = nb - s_ext;
  assign a_mag = a3[N-1] ? N'(-a3) : N'(a3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= sq_v[S_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3_r[0] <= np[NUM_SW-1] ? NUM_W'(-np) : NUM_W'(np);
      num3_r[1] <= nm[NUM_SW-1] ? NUM_W'(-nm) : NUM_W'(nm);
      den3_r    <= {a_mag, 1'b0};
      side3_r   <= {abc3, fl3, np[NUM_SW-1] ^ a3[N-1], nm[NUM_SW-1] ^ a3[N-1]};
    end
  end

  // Divider chain, one quotient bit of each root per cell.
  logic                  dv_v    [NUM_W+1];
  logic [1:0][NUM_W-1:0] dv_num  [NUM_W+1];
  logic [1:0][DEN_W-1:0] dv_rem  [NUM_W+1];
  logic [1:0][NUM_W-1:0] dv_quo  [NUM_W+1];
  logic [DEN_W-1:0]      dv_den  [NUM_W+1];
  logic [DV_SIDE-1:0]    dv_side [NUM_W+1];

  assign dv_v[0]    = v3_r;
  assign dv_num[0]  = num3_r;
  assign dv_rem[0]  = '0;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = den3_r;
  assign dv_side[0] = side3_r;

  for (genvar gj = 0; gj < NUM_W; gj++) begin : g_div
    qrs_div_cell #(
      .NUM_W  (NUM_W),
      .DEN_W  (DEN_W),
      .SIDE_W (DV_SIDE)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[gj]),
      .num_i  (dv_num[gj]),
      .rem_i  (dv_rem[gj]),
      .quo_i  (dv_quo[gj]),
      .den_i  (dv_den[gj]),
      .side_i (dv_side[gj]),
      .v_o    (dv_v[gj+1]),
      .num_o  (dv_num[gj+1]),
      .rem_o  (dv_rem[gj+1]),
      .quo_o  (dv_quo[gj+1]),
      .den_o  (dv_den[gj+1]),
      .side_o (dv_side[gj+1])
    );
  end

  // Stage 4: sign, truncation toward zero and saturation to 32 bits.
  // A zero leading coefficient or a negative discriminant forces both roots to zero.
  logic [1:0]              sgn4;
  qrs_flags_t              fl4;
  logic [1:0][CMP_W-1:0]   qmag;
  logic [1:0][CMP_W-1:0]   qneg;
  logic [1:0][ROOT_W-1:0]  x_nxt;
  logic                    v4_r;
  logic [1:0][ROOT_W-1:0]  x4_r;
  logic [ABC_W-1:0]        abc4_r;
  qrs_flags_t              fl4_r;

  assign sgn4 = {dv_side[NUM_W][0], dv_side[NUM_W][1]};
  assign fl4  = dv_side[NUM_W][3:2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      qmag[i] = CMP_W'(dv_quo[NUM_W][i]);
      qneg[i] = -qmag[i];
      if (fl4.azero || fl4.noreal) begin
        x_nxt[i] = '0;
      end else if (!sgn4[i]) begin
        x_nxt[i] = (qmag[i] > POS_LIM) ? ROOT_W'(POS_LIM) : qmag[i][ROOT_W-1:0];
      end else begin
        x_nxt[i] = (qmag[i] > NEG_LIM) ? ROOT_W'(NEG_LIM) : qneg[i][ROOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= dv_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4_r   <= x_nxt;
      abc4_r <= dv_side[NUM_W][DV_SIDE-1 -: ABC_W];
      fl4_r  <= fl4;
    end
  end

  // Residual of each root, with the word's other fields delayed alongside.
  logic [1:0] fail;

  for (genvar gk = 0; gk < 2; gk++) begin : g_res
    qrs_resid #(
      .COEF_BITS      (COEF_BITS),
      .ROOT_FRAC_BITS (ROOT_FRAC_BITS)
    ) u_resid (
      .clk     (clk),
      .en      (en),
      .a_i     (abc4_r[ABC_W-1 -: N]),
      .b_i     (abc4_r[ABC_W-N-1 -: N]),
      .c_i     (abc4_r[N-1:0]),
      .x_i     (x4_r[gk]),
      .limit_i (limit_r),
      .fail_o  (fail[gk])
    );
  end

  logic [RES_LAT-1:0]     rd_v_r;
  logic [1:0][ROOT_W-1:0] rd_x_r  [RES_LAT];
  qrs_flags_t             rd_fl_r [RES_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= '0;
    end else if (en) begin
      rd_v_r <= {rd_v_r[RES_LAT-2:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_x_r[0]  <= x4_r;
      rd_fl_r[0] <= fl4_r;
      for (int i = 1; i < RES_LAT; i++) begin
        rd_x_r[i]  <= rd_x_r[i-1];
        rd_fl_r[i] <= rd_fl_r[i-1];
      end
    end
  end

  // Final status.
  qrs_flags_t fl_end;
  status_t    st_end;
  logic       arrive;

  assign fl_end = rd_fl_r[RES_LAT-1];
  assign arrive = rd_v_r[RES_LAT-1] && en;

  always_comb begin
    priority if (fl_end.azero) begin
      st_end = ST_AZERO;
    end else if (fl_end.noreal) begin
      st_end = ST_NOREAL;
    end else if (fail != 2'b00) begin
      st_end = ST_RESID;
    end else begin
      st_end = ST_OK;
    end
  end

  // Output register with a one-word skid register behind it.
  logic    out_v_r, skid_v_r;
  root_t   out_p_r, out_m_r, skid_p_r, skid_m_r;
  status_t out_s_r, skid_s_r;
  logic    pop;

  assign pop = out_v_r && out_root.ready;
  assign en  = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= arrive;
      end
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_p_r <= skid_p_r;
        out_m_r <= skid_m_r;
        out_s_r <= skid_s_r;
      end else begin
        out_p_r <= rd_x_r[RES_LAT-1][0];
        out_m_r <= rd_x_r[RES_LAT-1][1];
        out_s_r <= st_end;
      end
    end else if (arrive) begin
      skid_p_r <= rd_x_r[RES_LAT-1][0];
      skid_m_r <= rd_x_r[RES_LAT-1][1];
      skid_s_r <= st_end;
    end
  end

  assign in_coef.ready       = en;
  assign out_root.valid      = out_v_r;
  assign out_root.root_plus  = out_p_r;
  assign out_root.root_minus = out_m_r;
  assign out_root.status     = out_s_r;

endmodule

FILE: rtl/qrs_checker.sv
// Port-level checks of the root solver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qrs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input qrs_pkg::root_t   root_plus,
  input qrs_pkg::root_t   root_minus,
  input qrs_pkg::status_t status
);
  import qrs_pkg::*;

  logic [2*ROOT_W+STATUS_W-1:0] out_word;
  logic                         special;
  logic                         zero_roots;

  assign out_word   = {root_plus, root_minus, status};
  assign special    = (status == ST_AZERO) || (status == ST_NOREAL);
  assign zero_roots = (root_plus == '0) && (root_minus == '0);

  // A waiting word stays offered.
  `QRS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output word dropped")

  // A waiting word does not change.
  `QRS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_word), "word changed")

  // Once the sink takes words the skid register drains and input opens again.
  `QRS_ASSERT(a_drain, clk, rst_n, out_ready |=> in_ready, "input still blocked after drain")

  // Special cases carry zero roots.
  `QRS_ASSERT(a_special_zero, clk, rst_n, out_valid && special |-> zero_roots, "nonzero roots")

  // Reset leaves no word on the output.
  `QRS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_coef.ready),
  .out_valid  (out_root.valid),
  .out_ready  (out_root.ready),
  .root_plus  (out_root.root_plus),
  .root_minus (out_root.root_minus),
  .status     (out_root.status)
);
